FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the files that check their own logic.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cqpw_pkg.sv
// ----------------------------------------------------------------------------
// cqpw_pkg
// Types, constants and helpers of the circular queue with positional write.
// ----------------------------------------------------------------------------
package cqpw_pkg;

    // Queue depth and derived widths.
    localparam int DEPTH  = 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Operation codes carried in the mode field.
    typedef enum logic [1:0] {
        MODE_INSERT  = 2'd0,
        MODE_DELETE  = 2'd1,
        MODE_MODIFY  = 2'd2,
        MODE_DISPLAY = 2'd3
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;     // perform the insert or modify write
        logic rd_start;  // read the front entry, reset the walk offset
        logic rd_next;   // read the entry after the current walk offset
        logic out_load;  // load the output word register
        logic from_ram;  // output word takes the RAM read data
        logic out_last;  // last flag for a word taken from the RAM
        logic pop;       // retire the front entry
    } cqpw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic do_write;  // accepted word is an insert or modify that succeeds
        logic do_read;   // accepted word is a delete or display of a non-empty queue
        logic is_delete; // accepted word is a delete
        logic last_idx;  // walk offset points at the rear entry
        logic empty;     // queue holds no entry
    } cqpw_stat_t;

    // Add an offset to a ring index, wrapping at the queue depth.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] offs);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= (IDX_W + 1)'(DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

FILE: src/cqpw_if.sv
// ----------------------------------------------------------------------------
// cqpw_if
// Valid/ready channels of the circular queue: request words and result words.
// ----------------------------------------------------------------------------
interface cqpw_req_if;
    import cqpw_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, mode, value, position, input ready);
    modport sink   (input valid, mode, value, position, output ready);
endinterface

interface cqpw_rsp_if;
    import cqpw_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic                     last;

    modport source (output valid, status, data, last, input ready);
    modport sink   (input valid, status, data, last, output ready);
endinterface

FILE: src/cqpw_ram.sv
// ----------------------------------------------------------------------------
// cqpw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cqpw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/cqpw_dpath.sv
// ----------------------------------------------------------------------------
// cqpw_dpath
// Datapath: ring pointers, entry storage, request decode and result register.
// ----------------------------------------------------------------------------
module cqpw_dpath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [1:0]                             mode,
    input  logic signed [cqpw_pkg::DATA_W-1:0]     value,
    input  logic [cqpw_pkg::POS_W-1:0]             position,
    input  cqpw_pkg::cqpw_cmd_t                    cmd,
    output cqpw_pkg::cqpw_stat_t                   stat,
    output logic [1:0]                             status,
    output logic signed [cqpw_pkg::DATA_W-1:0]     data,
    output logic                                   last
);
    import cqpw_pkg::*;

    logic [IDX_W-1:0]         front_reg, front_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [1:0]               status_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic                     last_reg;

    logic                     empty;
    logic                     full;
    logic                     pos_ok;
    status_t                  res_status;
    logic [IDX_W-1:0]         wr_addr;
    logic [IDX_W-1:0]         rd_addr;
    logic [DATA_W-1:0]        rd_data;

    // Occupancy and position checks.
    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign pos_ok = (position != '0) && (CMP_W'(position) <= CMP_W'(count_reg));

    // Result code for a word that is answered without reading the storage.
    always_comb
    begin
        res_status = ST_OK;
        unique case (mode)
            MODE_INSERT:  res_status = full ? ST_FULL : ST_OK;
            MODE_MODIFY:  res_status = empty ? ST_EMPTY : (pos_ok ? ST_OK : ST_BADPOS);
            MODE_DELETE,
            MODE_DISPLAY: res_status = empty ? ST_EMPTY : ST_OK;
            default:      res_status = ST_OK;
        endcase
    end

    // Decode for the controller.
    assign stat.do_write  = ((mode == MODE_INSERT) && !full) ||
                            ((mode == MODE_MODIFY) && !empty && pos_ok);
    assign stat.do_read   = ((mode == MODE_DELETE) || (mode == MODE_DISPLAY)) && !empty;
    assign stat.is_delete = (mode == MODE_DELETE);
    assign stat.last_idx  = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));
    assign stat.empty     = empty;

    // Write goes behind the rear for insert, at the given place for modify.
    assign wr_addr = (mode == MODE_INSERT) ?
                     wrap_add(front_reg, count_reg[IDX_W-1:0]) :
                     wrap_add(front_reg, IDX_W'(position - POS_W'(1)));

    // Reads walk from the front entry.
    assign rd_addr = cmd.rd_next ? wrap_add(front_reg, idx_reg + IDX_W'(1)) : front_reg;

    cqpw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata (value),
        .re    (cmd.rd_start || cmd.rd_next),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Pointer and walk offset updates.
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        if (cmd.wr_en && (mode == MODE_INSERT))
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
            front_next = (count_reg == CNT_W'(1)) ? '0 : wrap_add(front_reg, IDX_W'(1));
        end
        if (cmd.rd_start)
        begin
            idx_next = '0;
        end
        else if (cmd.rd_next)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.from_ram)
            begin
                status_reg <= ST_OK;
                data_reg   <= rd_data;
                last_reg   <= cmd.out_last;
            end
            else
            begin
                status_reg <= res_status;
                data_reg   <= '0;
                last_reg   <= 1'b1;
            end
        end
    end

    assign status = status_reg;
    assign data   = data_reg;
    assign last   = last_reg;

endmodule

FILE: src/cqpw_ctrl.sv
// ----------------------------------------------------------------------------
// cqpw_ctrl
// Controller: request and result handshakes, read sequencing for delete and
// display.
// ----------------------------------------------------------------------------
module cqpw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  cqpw_pkg::cqpw_stat_t stat,
    output cqpw_pkg::cqpw_cmd_t  cmd
);
    import cqpw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   del_reg, del_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   slot_free;
    logic   accept;

    // The result register is free when empty or being taken this cycle.
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = req_valid && req_ready;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        del_next   = del_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (stat.do_read)
                    begin
                        cmd.rd_start = 1'b1;
                        del_next     = stat.is_delete;
                        state_next   = S_READ;
                    end
                    else
                    begin
                        cmd.wr_en    = stat.do_write;
                        cmd.out_load = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.from_ram = 1'b1;
                    cmd.out_last = del_reg || stat.last_idx;
                    cmd.pop      = del_reg;
                    if (del_reg || stat.last_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            del_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            del_reg       <= del_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

FILE: src/circular_queue_with_positional_write.sv
// ----------------------------------------------------------------------------
// circular_queue_with_positional_write
// Fixed-depth circular queue of signed words with insert, delete, modify at a
// position counted from the front, and display of all held words.
//
//   Channel | Dir | Payload                      | Handshake
//   req     | in  | mode, value, position        | valid / ready
//   rsp     | out | status, data, last           | valid / ready
//
// Insert, modify and every error case answer from the request cycle; such
// words are taken every cycle while rsp is drained.
// Delete reads the front entry through the registered read of the entry RAM.
// Display streams each held word through the RAM, from the front to the rear.
// Reset clears the pointers, the fill count and the walk offset; entries need no clearing.
// A stalled rsp holds the result and stops the read walk until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circular_queue_with_positional_write (
    input logic   clk,
    input logic   rst_n,
    cqpw_req_if.sink   req,
    cqpw_rsp_if.source rsp
);
    import cqpw_pkg::*;

    cqpw_cmd_t  cmd;
    cqpw_stat_t stat;

    cqpw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cqpw_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (req.mode),
        .value    (req.value),
        .position (req.position),
        .cmd      (cmd),
        .stat     (stat),
        .status   (rsp.status),
        .data     (rsp.data),
        .last     (rsp.last)
    );

    // A read walk blocks new requests on the following cycle.
    `ASSERT_NEXT(a_busy_after_read, clk, rst_n, cmd.rd_start, !req.ready, "request taken during read walk")

    // Storage is never written while a walk advances.
    `ASSERT_NOW(a_no_write_in_walk, clk, rst_n, cmd.rd_next, !cmd.wr_en, "write during read walk")

    // An entry is only retired from a non-empty queue.
    `ASSERT_NOW(a_pop_nonempty, clk, rst_n, cmd.pop, !stat.empty, "delete from empty queue")

    // A result from storage always carries ok status on the next cycle.
    `ASSERT_NEXT(a_ram_word_ok, clk, rst_n, cmd.out_load && cmd.from_ram, rsp.valid && (rsp.status == ST_OK), "stored word not presented")

endmodule
